/* hdl/mbps_pkg.sv */
// Shared types, register indexes and lane compare function for the masked byte pattern scan.
package mbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF       = 32;
   localparam int LANE_COUNT            = 16;
   localparam int LANE_BITS             = 4;
   localparam int LEN_BITS              = 5;
   localparam int CSR_INDEX_BITS        = 3;
   localparam int CSR_DATA_BITS         = 64;
   localparam int RESULT_OFFSET_BITS    = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_LOW     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 3'd4;

   typedef logic [LEN_BITS-1:0] len_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic [RESULT_OFFSET_BITS-1:0] match_offset;
   } rsp_type;

   typedef struct packed {
      logic [8*LANE_COUNT-1:0] pattern;
      logic [8*LANE_COUNT-1:0] mask;
   } cfg_type;

   // Byte at distance pos behind the newest byte meets pattern lane len-1-pos.
   function automatic logic lane_hit(logic [7:0] b, cfg_type cfg, len_type len,
                                     logic [LANE_BITS-1:0] pos);
      logic                 active;
      logic [LANE_BITS-1:0] lane;
      logic [7:0]           m;
      logic [7:0]           p;
      active = len > {1'b0, pos};
      lane   = LANE_BITS'(len - len_type'(1) - {1'b0, pos});
      m      = cfg.mask[{lane, 3'b000} +: 8];
      p      = cfg.pattern[{lane, 3'b000} +: 8];
      return !active || ((b & m) == p);
   endfunction

endpackage

/* hdl/mbps_cell.sv */
// One window cell: holds a past byte, passes it on, and compares it with its pattern lane.
module mbps_cell #(
   parameter int POS = 1
) (
   input  logic            clock,
   input  logic            shift,
   input  logic [7:0]      byte_in,
   input  mbps_pkg::cfg_type cfg,
   input  mbps_pkg::len_type len,
   output logic [7:0]      byte_out,
   output logic            hit
);
   import mbps_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_next_in;

   assign byte_next_in = shift ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_next_in;
   end

   assign byte_out = byte_ff;
   assign hit      = lane_hit(byte_ff, cfg, len, LANE_BITS'(POS));

endmodule

/* hdl/masked_byte_pattern_scan.sv */
// Top level: streaming masked byte pattern search over a chain of window cells.
//
//   port group  dir  handshake               carries
//   req_*       in   req_valid / req_ready   one region byte and end flag per item
//   rsp_*       out  rsp_valid / rsp_ready   found flag and match start offset
//   csr_*       in   csr_valid / csr_ready   register index and 64-bit write data
//
// One item per cycle while req_ready is high; every window compare runs in parallel across the cells.
// A result sits in the output register from the cycle after its item is accepted.
// req_ready drops only while a result waits and rsp_ready is low.
// Reset clears configuration to defaults, counter, match flag and output valid.
// csr_ready is always high.
module masked_byte_pattern_scan #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mbps_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mbps_pkg::rsp_type                   rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mbps_pkg::*;

   localparam int EXT_BITS = (OFFSET_BITS > RESULT_OFFSET_BITS) ? OFFSET_BITS
                                                                : RESULT_OFFSET_BITS;

   cfg_type                cfg_ff, cfg_in;
   len_type                len_reg_ff, len_reg_in;
   len_type                len_eff;
   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                   match_done_ff, match_done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_item_ff, rsp_item_in;

   logic                   req_accept;
   logic                   shift;
   logic [MAX_PATTERN_BYTES-1:0] hits;
   logic                   hit_now;
   logic                   emit;
   logic [OFFSET_BITS-1:0] len_less_one;
   logic [OFFSET_BITS-1:0] offset_diff;
   logic [EXT_BITS-1:0]    offset_ext;

   // Configuration
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in     = cfg_ff;
      len_reg_in = len_reg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  cfg_in.pattern[63:0]   = csr_wdata;
            CSR_PATTERN_HIGH: cfg_in.pattern[127:64] = csr_wdata;
            CSR_MASK_LOW:     cfg_in.mask[63:0]      = csr_wdata;
            CSR_MASK_HIGH:    cfg_in.mask[127:64]    = csr_wdata;
            CSR_PATTERN_LEN:  len_reg_in             = csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (len_reg_ff == len_type'(0)) begin
         len_eff = len_type'(1);
      end else if (len_reg_ff > len_type'(MAX_PATTERN_BYTES)) begin
         len_eff = len_type'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = len_reg_ff;
      end
   end

   // Window chain
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign shift      = req_accept && !match_done_ff;

   assign hits[0] = lane_hit(req_item.data_byte, cfg_ff, len_eff, LANE_BITS'(0));

   generate
      if (MAX_PATTERN_BYTES > 1) begin : g_chain
         logic [7:0] link [1:MAX_PATTERN_BYTES-1];
         assign link[1] = req_item.data_byte;
         for (genvar k = 1; k < MAX_PATTERN_BYTES; k++) begin : g_cell
            if (k < MAX_PATTERN_BYTES - 1) begin : g_mid
               mbps_cell #(.POS(k)) u_cell (
                  .clock    (clock),
                  .shift    (shift),
                  .byte_in  (link[k]),
                  .cfg      (cfg_ff),
                  .len      (len_eff),
                  .byte_out (link[k+1]),
                  .hit      (hits[k])
               );
            end else begin : g_last
               mbps_cell #(.POS(k)) u_cell (
                  .clock    (clock),
                  .shift    (shift),
                  .byte_in  (link[k]),
                  .cfg      (cfg_ff),
                  .len      (len_eff),
                  .byte_out (),
                  .hit      (hits[k])
               );
            end
         end
      end
   endgenerate

   // Match decision and counter
   assign len_less_one = OFFSET_BITS'(len_eff - len_type'(1));
   assign hit_now      = !match_done_ff && (bytes_seen_ff >= len_less_one) && (&hits);
   assign emit         = hit_now || (req_item.region_end && !match_done_ff);
   assign offset_diff  = bytes_seen_ff - len_less_one;
   assign offset_ext   = EXT_BITS'(offset_diff);

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      match_done_in = match_done_ff;
      if (req_accept) begin
         if (req_item.region_end) begin
            bytes_seen_in = '0;
            match_done_in = 1'b0;
         end else if (!match_done_ff) begin
            match_done_in = hit_now;
            if (bytes_seen_ff != {OFFSET_BITS{1'b1}}) begin
               bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
            end
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (req_accept && emit) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.found        = hit_now;
         rsp_item_in.match_offset = hit_now ? offset_ext[RESULT_OFFSET_BITS-1:0] : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         len_reg_ff    <= len_type'(1);
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         len_reg_ff    <= len_reg_in;
         bytes_seen_ff <= bytes_seen_in;
         match_done_ff <= match_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_region_end_rearms: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_item.region_end |=> !match_done_ff && (bytes_seen_ff == '0))
      else $error("region end did not rearm the scan");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_item.region_end && !match_done_ff |=> bytes_seen_ff != '0)
      else $error("byte count did not advance");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.found |-> rsp_item_ff.match_offset == '0)
      else $error("not-found item carries an offset");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && match_done_ff |-> !hit_now)
      else $error("second match reported in one region");

endmodule
